[rtl/lcd4_pkg.sv]
// ----------------------------------------------------------------------------
// lcd4_pkg
// Shared types, codes and helpers for the 4-bit character LCD controller.
// ----------------------------------------------------------------------------
package lcd4_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] REQ_INIT = 2'd0;
	localparam logic [1:0] REQ_CMD  = 2'd1;
	localparam logic [1:0] REQ_DATA = 2'd2;
	localparam logic [1:0] REQ_POS  = 2'd3;

	localparam logic [1:0] CFG_PULSE  = 2'd0;
	localparam logic [1:0] CFG_SETTLE = 2'd1;
	localparam logic [1:0] CFG_EXTRA  = 2'd2;
	localparam logic [1:0] CFG_POWER  = 2'd3;

	localparam logic [7:0]  RST_PULSE  = 8'd5;
	localparam logic [15:0] RST_SETTLE = 16'd5500;
	localparam logic [7:0]  RST_EXTRA  = 8'd5;
	localparam logic [15:0] RST_POWER  = 16'd33000;

	// row base minus one, so base + column - 1 is one add
	localparam logic [7:0] ROW1_BM1 = 8'd127;
	localparam logic [7:0] ROW2_BM1 = 8'd191;
	localparam logic [7:0] ROW3_BM1 = 8'd147;
	localparam logic [7:0] ROW4_BM1 = 8'd211;

	localparam logic [7:0] CMD_FUNC_SET = 8'd40;
	localparam logic [7:0] CMD_SHIFT    = 8'd16;
	localparam logic [7:0] CMD_CLEAR    = 8'd1;
	localparam logic [7:0] CMD_DISPLAY  = 8'd15;
	localparam logic [7:0] WAKE_8BIT    = 8'h03;
	localparam logic [7:0] WAKE_4BIT    = 8'h02;

	localparam logic [3:0] INIT_LAST_UNIT = 4'd8;
	localparam logic [2:0] PWR_LAST_PH    = 3'd0;
	localparam logic [2:0] WAKE_LAST_PH   = 3'd2;
	localparam logic [2:0] BYTE_LAST_PH   = 3'd4;

	typedef enum logic [1:0] {
		OP_INIT = 2'd0,
		OP_CMD  = 2'd1,
		OP_DATA = 2'd2,
		OP_POS  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		U_PWR  = 3'b001,
		U_WAKE = 3'b010,
		U_BYTE = 3'b100
	} unit_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] value;
		logic [7:0] addr;
	} entry_t;

	typedef struct packed {
		unit_t      kind;
		logic [7:0] value;
		logic       rs;
		logic       last;
	} unit_desc_t;

	typedef struct packed {
		logic [7:0]  pulse_width_us;
		logic [15:0] settle_us;
		logic [7:0]  char_extra_us;
		logic [15:0] power_up_us;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  data_nibble;
		logic        reg_select;
		logic        enable;
		logic [15:0] hold_us;
		logic        last;
	} phase_t;

	function automatic unit_desc_t unit_of(entry_t e, logic [3:0] idx);
		unit_desc_t d;
		d = '{kind: U_BYTE, value: e.value, rs: 1'b0, last: 1'b1};
		unique case (e.op)
			OP_INIT: begin
				d.last = (idx == INIT_LAST_UNIT);
				unique case (idx)
					4'd0:    d.kind = U_PWR;
					4'd1, 4'd2, 4'd3: begin
						d.kind = U_WAKE;
						d.value = WAKE_8BIT;
					end
					4'd4: begin
						d.kind = U_WAKE;
						d.value = WAKE_4BIT;
					end
					4'd5:    d.value = CMD_FUNC_SET;
					4'd6:    d.value = CMD_SHIFT;
					4'd7:    d.value = CMD_CLEAR;
					default: d.value = CMD_DISPLAY;
				endcase
			end
			OP_CMD: d.rs = 1'b0;
			OP_DATA: d.rs = 1'b1;
			OP_POS: begin
				if (idx == 4'd0) begin
					d.value = e.addr;
					d.last = 1'b0;
				end else begin
					d.rs = 1'b1;
				end
			end
			default: d.rs = 1'b0;
		endcase
		return d;
	endfunction

endpackage

[rtl/lcd4_front.sv]
// ----------------------------------------------------------------------------
// lcd4_front
// Classifies requests and computes the cursor address before queueing.
// ----------------------------------------------------------------------------
module lcd4_front (
	input  logic              start,
	input  logic              q_full,
	input  logic [1:0]        req_type,
	input  logic [7:0]        byte_value,
	input  logic [2:0]        row,
	input  logic [4:0]        column,
	output logic              busy,
	output logic              push,
	output lcd4_pkg::entry_t  entry
);
	import lcd4_pkg::*;

	logic [7:0] bm1;
	logic       row_ok;

	always_comb begin
		row_ok = 1'b1;
		unique case (row)
			3'd1:    bm1 = ROW1_BM1;
			3'd2:    bm1 = ROW2_BM1;
			3'd3:    bm1 = ROW3_BM1;
			3'd4:    bm1 = ROW4_BM1;
			default: begin
				bm1 = '0;
				row_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		entry.value = byte_value;
		entry.addr = bm1 + {3'b000, column};
		unique case (req_type)
			REQ_INIT: entry.op = OP_INIT;
			REQ_CMD:  entry.op = OP_CMD;
			REQ_DATA: entry.op = OP_DATA;
			default:  entry.op = row_ok ? OP_POS : OP_DATA;
		endcase
	end

	assign busy = q_full;
	assign push = start && !q_full;

endmodule

[rtl/lcd4_queue.sv]
// ----------------------------------------------------------------------------
// lcd4_queue
// Short request queue between the front and the phase sequencer.
// ----------------------------------------------------------------------------
module lcd4_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lcd4_pkg::entry_t  wr_entry,
	input  logic              pop,
	output lcd4_pkg::entry_t  rd_entry,
	output logic              empty,
	output logic              full
);
	import lcd4_pkg::*;

	entry_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == QCNT_W'(QDEPTH));
	assign rd_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH)) else $error("queue count out of range");

endmodule

[rtl/lcd4_back.sv]
// ----------------------------------------------------------------------------
// lcd4_back
// Phase sequencer: expands one queued request into timed pin phases.
// ----------------------------------------------------------------------------
module lcd4_back (
	input  logic              clk,
	input  logic              arst_n,
	input  lcd4_pkg::cfg_t    cfg,
	input  lcd4_pkg::entry_t  head,
	input  logic              q_empty,
	output logic              pop,
	output logic              strobe,
	output lcd4_pkg::phase_t  phase
);
	import lcd4_pkg::*;

	logic [3:0]  unit_q;
	logic [2:0]  ph_q;
	unit_desc_t  ud;
	phase_t      nxt;
	logic        unit_end;
	logic [16:0] sum;
	logic [15:0] wait_us;
	logic        strobe_q;
	phase_t      phase_q;

	assign ud = unit_of(head, unit_q);
	assign sum = {1'b0, cfg.settle_us} + {9'b0, cfg.char_extra_us};

	always_comb begin
		if (ud.rs) begin
			wait_us = sum[16] ? 16'hFFFF : sum[15:0];
		end else begin
			wait_us = cfg.settle_us;
		end
	end

	always_comb begin
		nxt = '0;
		unit_end = 1'b0;
		unique case (ud.kind)
			U_PWR: begin
				nxt.hold_us = cfg.power_up_us;
				unit_end = (ph_q == PWR_LAST_PH);
			end
			U_WAKE: begin
				nxt.data_nibble = ud.value[3:0];
				nxt.enable = (ph_q == 3'd1);
				priority case (ph_q)
					3'd1:    nxt.hold_us = {8'b0, cfg.pulse_width_us};
					3'd2:    nxt.hold_us = cfg.settle_us;
					default: nxt.hold_us = '0;
				endcase
				unit_end = (ph_q == WAKE_LAST_PH);
			end
			default: begin
				nxt.data_nibble = (ph_q < 3'd2) ? ud.value[7:4] : ud.value[3:0];
				nxt.reg_select = ud.rs;
				nxt.enable = (ph_q == 3'd1) || (ph_q == 3'd3);
				priority case (ph_q)
					3'd1, 3'd3: nxt.hold_us = {8'b0, cfg.pulse_width_us};
					3'd4:       nxt.hold_us = wait_us;
					default:    nxt.hold_us = '0;
				endcase
				unit_end = (ph_q == BYTE_LAST_PH);
			end
		endcase
		nxt.last = ud.last && unit_end;
	end

	assign pop = !q_empty && nxt.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= '0;
			ph_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= !q_empty;
			if (!q_empty) begin
				if (nxt.last) begin
					unit_q <= '0;
					ph_q <= '0;
				end else if (unit_end) begin
					unit_q <= unit_q + 1'b1;
					ph_q <= '0;
				end else begin
					ph_q <= ph_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		phase_q <= nxt;
	end

	assign strobe = strobe_q;
	assign phase = phase_q;

	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> (unit_q == '0) && (ph_q == '0))
		else $error("sequencer counters not at rest while queue empty");
	a_pop_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> strobe_q && phase_q.last) else $error("pop without last phase");
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		unit_q <= INIT_LAST_UNIT) else $error("unit index out of range");

endmodule

[rtl/char_lcd_4bit_interface.sv]
// ----------------------------------------------------------------------------
// char_lcd_4bit_interface
// 4-bit character LCD controller: turns requests into timed pin phases.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start / busy         req_type, byte_value, row, column
//  result    strobe               data_nibble, reg_select, enable, hold_us, last
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One phase per cycle from the back sequencer while a request is queued:
//  a request expands into 5, 10 or 33 phases. A request is taken in any
//  cycle in which the four-entry queue has room, so the next one waits in
//  the queue while the current one plays out. Results are registered and
//  appear in the cycle after the sequencer step. Reset clears the queue
//  and sequencer and loads the default timings. The receiver cannot stall.
// ----------------------------------------------------------------------------
module char_lcd_4bit_interface (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [7:0]  byte_value,
	input  logic [2:0]  row,
	input  logic [4:0]  column,
	output logic        strobe,
	output logic [3:0]  data_nibble,
	output logic        reg_select,
	output logic        enable,
	output logic [15:0] hold_us,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import lcd4_pkg::*;

	cfg_t   cfg_q;
	entry_t wr_entry;
	entry_t head;
	logic   push;
	logic   pop;
	logic   q_empty;
	logic   q_full;
	phase_t phase;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{pulse_width_us: RST_PULSE, settle_us: RST_SETTLE,
			           char_extra_us: RST_EXTRA, power_up_us: RST_POWER};
		end else if (cfg_valid && cfg_ready && (cfg_index[3:2] == 2'b00)) begin
			unique case (cfg_index[1:0])
				CFG_PULSE:  cfg_q.pulse_width_us <= cfg_data[7:0];
				CFG_SETTLE: cfg_q.settle_us <= cfg_data;
				CFG_EXTRA:  cfg_q.char_extra_us <= cfg_data[7:0];
				default:    cfg_q.power_up_us <= cfg_data;
			endcase
		end
	end

	lcd4_front u_front (
		.start      (start),
		.q_full     (q_full),
		.req_type   (req_type),
		.byte_value (byte_value),
		.row        (row),
		.column     (column),
		.busy       (busy),
		.push       (push),
		.entry      (wr_entry)
	);

	lcd4_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	lcd4_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.strobe  (strobe),
		.phase   (phase)
	);

	assign data_nibble = phase.data_nibble;
	assign reg_select = phase.reg_select;
	assign enable = phase.enable;
	assign hold_us = phase.hold_us;
	assign last = phase.last;

endmodule

[tb/tb_char_lcd_4bit_interface.sv]
// ----------------------------------------------------------------------------
// tb_char_lcd_4bit_interface
// Self-checking bench for the 4-bit character LCD controller. Every accepted
// request is expanded into its expected pin phases; each strobed phase is
// checked field by field against the oldest pending one. A directed set of
// requests comes first, then random traffic under several timing settings
// and sender idle rates.
// ----------------------------------------------------------------------------
module tb_char_lcd_4bit_interface;
	timeunit 1ns;
	timeprecision 1ps;

	import lcd4_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 4;
	localparam int TAIL_CYCLES = 20;
	localparam int RAND_PHASES = 4;
	localparam int ITEMS_PER_PHASE = 45;
	localparam logic [3:0] REG_FIRST_UNUSED = 4'd4;
	localparam logic [3:0] REG_LAST_UNUSED = 4'd15;

	class lcd_phase_scoreboard;
		phase_t pending[$];
		phase_t burst[$];
		cfg_t timing;
		int mismatches;
		int requests;
		int phases;

		function new();
			timing.pulse_width_us = RST_PULSE;
			timing.settle_us = RST_SETTLE;
			timing.char_extra_us = RST_EXTRA;
			timing.power_up_us = RST_POWER;
			mismatches = 0;
			requests = 0;
			phases = 0;
		endfunction

		function void set_reg(logic [3:0] idx, logic [15:0] data);
			case (idx)
				CFG_PULSE: timing.pulse_width_us = data[7:0];
				CFG_SETTLE: timing.settle_us = data;
				CFG_EXTRA: timing.char_extra_us = data[7:0];
				CFG_POWER: timing.power_up_us = data;
				default: ;
			endcase
		endfunction

		function void add_phase(logic [3:0] nib, logic rs, logic en, logic [15:0] hold);
			phase_t p;
			p.data_nibble = nib;
			p.reg_select = rs;
			p.enable = en;
			p.hold_us = hold;
			p.last = 1'b0;
			burst.push_back(p);
		endfunction

		function void add_byte(logic [7:0] b, logic rs);
			logic [16:0] settle_sum;
			logic [15:0] pulse;
			pulse = {8'd0, timing.pulse_width_us};
			settle_sum = {1'b0, timing.settle_us};
			if (rs) begin
				settle_sum = settle_sum + {9'd0, timing.char_extra_us};
				if (settle_sum > 17'h0FFFF)
					settle_sum = 17'h0FFFF;
			end
			add_phase(b[7:4], rs, 1'b0, 16'd0);
			add_phase(b[7:4], rs, 1'b1, pulse);
			add_phase(b[3:0], rs, 1'b0, 16'd0);
			add_phase(b[3:0], rs, 1'b1, pulse);
			add_phase(b[3:0], rs, 1'b0, settle_sum[15:0]);
		endfunction

		function void add_wakeup(logic [3:0] nib);
			add_phase(nib, 1'b0, 1'b0, 16'd0);
			add_phase(nib, 1'b0, 1'b1, {8'd0, timing.pulse_width_us});
			add_phase(nib, 1'b0, 1'b0, timing.settle_us);
		endfunction

		function void note_request(logic [1:0] kind, logic [7:0] b, logic [2:0] row_sel,
				logic [4:0] col);
			logic [7:0] base_m1;
			logic addressed;
			phase_t tail;
			burst.delete();
			addressed = 1'b1;
			base_m1 = 8'd0;
			case (kind)
				REQ_INIT: begin
					add_phase(4'd0, 1'b0, 1'b0, timing.power_up_us);
					repeat (3) add_wakeup(WAKE_8BIT[3:0]);
					add_wakeup(WAKE_4BIT[3:0]);
					add_byte(CMD_FUNC_SET, 1'b0);
					add_byte(CMD_SHIFT, 1'b0);
					add_byte(CMD_CLEAR, 1'b0);
					add_byte(CMD_DISPLAY, 1'b0);
				end
				REQ_CMD: add_byte(b, 1'b0);
				REQ_DATA: add_byte(b, 1'b1);
				default: begin
					case (row_sel)
						3'd1: base_m1 = ROW1_BM1;
						3'd2: base_m1 = ROW2_BM1;
						3'd3: base_m1 = ROW3_BM1;
						3'd4: base_m1 = ROW4_BM1;
						default: addressed = 1'b0;
					endcase
					if (addressed)
						add_byte(base_m1 + {3'b000, col}, 1'b0);
					add_byte(b, 1'b1);
				end
			endcase
			tail = burst.pop_back();
			tail.last = 1'b1;
			burst.push_back(tail);
			foreach (burst[i])
				pending.push_back(burst[i]);
			requests++;
		endfunction

		function void check_phase(phase_t got);
			phase_t want;
			phases++;
			if (pending.size() == 0) begin
				$error("unexpected phase: nibble %0h rs %0b en %0b hold %0d last %0b",
					got.data_nibble, got.reg_select, got.enable, got.hold_us, got.last);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			if (got.data_nibble !== want.data_nibble) begin
				$error("data_nibble: expected %0h, got %0h", want.data_nibble, got.data_nibble);
				mismatches++;
			end
			if (got.reg_select !== want.reg_select) begin
				$error("reg_select: expected %0b, got %0b", want.reg_select, got.reg_select);
				mismatches++;
			end
			if (got.enable !== want.enable) begin
				$error("enable: expected %0b, got %0b", want.enable, got.enable);
				mismatches++;
			end
			if (got.hold_us !== want.hold_us) begin
				$error("hold_us: expected %0d, got %0d", want.hold_us, got.hold_us);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [7:0]  byte_value;
	logic [2:0]  row;
	logic [4:0]  column;
	logic        strobe;
	logic [3:0]  data_nibble;
	logic        reg_select;
	logic        enable;
	logic [15:0] hold_us;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_index;
	logic [15:0] cfg_data;

	lcd_phase_scoreboard sb = new();
	int cycle_count = 0;
	int settings_run = 0;

	char_lcd_4bit_interface dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.byte_value (byte_value),
		.row        (row),
		.column     (column),
		.strobe     (strobe),
		.data_nibble(data_nibble),
		.reg_select (reg_select),
		.enable     (enable),
		.hold_us    (hold_us),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_phase({data_nibble, reg_select, enable, hold_us, last});
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// cfg_valid stays high across a batch; the caller lowers it
	task automatic write_reg(input logic [3:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	task automatic load_timing(input logic [15:0] pulse, input logic [15:0] settle,
			input logic [15:0] extra, input logic [15:0] power, input bit poke_unused);
		write_reg(CFG_PULSE, pulse);
		write_reg(CFG_SETTLE, settle);
		write_reg(CFG_EXTRA, extra);
		write_reg(CFG_POWER, power);
		if (poke_unused)
			write_reg(4'($urandom_range(REG_LAST_UNUSED, REG_FIRST_UNUSED)),
				16'($urandom));
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// start is left high after the transaction so back-to-back requests need no toggle
	task automatic send_request(input logic [1:0] kind, input logic [7:0] b,
			input logic [2:0] row_sel, input logic [4:0] col, input int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			req_type <= 2'($urandom);
			byte_value <= 8'($urandom);
			row <= 3'($urandom);
			column <= 5'($urandom);
			repeat ($urandom_range(12, 1)) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= kind;
		byte_value <= b;
		row <= row_sel;
		column <= col;
		do @(posedge clk); while (busy);
		sb.note_request(kind, b, row_sel, col);
	endtask

	task automatic pick_request(output logic [1:0] kind, output logic [7:0] b,
			output logic [2:0] row_sel, output logic [4:0] col);
		int sel;
		sel = $urandom_range(99);
		if (sel < 10)
			kind = REQ_INIT;
		else if (sel < 35)
			kind = REQ_CMD;
		else if (sel < 65)
			kind = REQ_DATA;
		else
			kind = REQ_POS;
		b = 8'($urandom);
		row_sel = 3'(($urandom_range(99) < 80) ? $urandom_range(4, 1) : $urandom_range(7, 0));
		col = 5'(($urandom_range(99) < 80) ? $urandom_range(20, 1) : $urandom_range(31, 0));
	endtask

	initial begin
		logic [1:0] k;
		logic [7:0] b;
		logic [2:0] r;
		logic [4:0] c;
		int idle_pct[RAND_PHASES];
		int ph;
		int n;

		idle_pct = '{0, 66, 0, 21};
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= REQ_INIT;
		byte_value <= 8'd0;
		row <= 3'd0;
		column <= 5'd0;
		cfg_valid <= 1'b0;
		cfg_index <= 4'd0;
		cfg_data <= 16'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed, default timing
		send_request(REQ_INIT, 8'h00, 3'd0, 5'd0, 0);
		send_request(REQ_CMD, 8'h00, 3'd7, 5'd31, 0);
		send_request(REQ_CMD, 8'hFF, 3'd2, 5'd9, 0);
		send_request(REQ_DATA, 8'h00, 3'd1, 5'd1, 0);
		send_request(REQ_DATA, 8'hFF, 3'd5, 5'd31, 0);
		send_request(REQ_DATA, 8'h5A, 3'd0, 5'd0, 0);
		send_request(REQ_POS, 8'h41, 3'd1, 5'd1, 0);
		send_request(REQ_POS, 8'h42, 3'd2, 5'd20, 0);
		send_request(REQ_POS, 8'h43, 3'd3, 5'd1, 0);
		send_request(REQ_POS, 8'h44, 3'd4, 5'd20, 0);
		send_request(REQ_POS, 8'h45, 3'd0, 5'd5, 0);
		send_request(REQ_POS, 8'h46, 3'd5, 5'd7, 0);
		send_request(REQ_POS, 8'h47, 3'd6, 5'd12, 0);
		send_request(REQ_POS, 8'h48, 3'd7, 5'd3, 0);
		send_request(REQ_POS, 8'hA5, 3'd1, 5'd0, 0);
		send_request(REQ_POS, 8'h3C, 3'd4, 5'd31, 0);

		// data settle saturation, plus a write to an unused index
		drain();
		load_timing(16'h0001, 16'hFFFF, 16'h00FF, 16'd0, 1'b1);
		send_request(REQ_DATA, 8'h33, 3'd0, 5'd0, 0);
		send_request(REQ_POS, 8'hC3, 3'd2, 5'd3, 0);
		send_request(REQ_INIT, 8'hFF, 3'd7, 5'd31, 0);

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			case (ph)
				0: load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
				1: load_timing(16'd1, 16'd0, 16'd0, 16'd0, 1'b0);
				2: load_timing(16'($urandom_range(255, 1)), 16'($urandom),
					16'($urandom_range(255, 0)), 16'($urandom), 1'b1);
				default: load_timing(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 1'b1);
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 1 && n == ITEMS_PER_PHASE / 2)
					drain();
				pick_request(k, b, r, c);
				send_request(k, b, r, c, idle_pct[ph]);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d requests and %0d pin phases checked under %0d timing settings",
			sb.requests, sb.phases, settings_run + 1);
		$display("mix: init, command, data and positioned writes, valid and invalid rows");
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			if (sb.pending.size() != 0)
				$error("%0d expected phases never arrived", sb.pending.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/lcd4_pkg.sv
rtl/lcd4_front.sv
rtl/lcd4_queue.sv
rtl/lcd4_back.sv
rtl/char_lcd_4bit_interface.sv
tb/tb_char_lcd_4bit_interface.sv
